@@ rtl/mtrp_pkg.sv @@
package mtrp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TRANS = 3'd1;
  localparam logic [2:0] ST_BAD_PROTO = 3'd2;
  localparam logic [2:0] ST_BAD_UNIT  = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_EXCEPTION = 3'd5;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Function codes that decode data.
  localparam logic [6:0] FC_READ_COILS  = 7'd1;
  localparam logic [6:0] FC_READ_INPUTS = 7'd2;
  localparam logic [6:0] FC_READ_HOLD   = 7'd3;
  localparam logic [6:0] FC_READ_INREG  = 7'd4;

  // Result queue between the parser and the output channel.
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        frame_start;
    logic [15:0] expected_transaction;
    logic [6:0]  expected_function;
    logic [10:0] requested_amount;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] data_word;
    logic [4:0]  bit_count;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } out_item_t;

  // Up to two results per byte; when both are pushed, item0 comes first.
  typedef struct packed {
    logic      push0;
    logic      push1;
    out_item_t item0;
    out_item_t item1;
  } parse_res_t;

endpackage

@@ rtl/mtrp_ifs.sv @@
interface mtrp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        frame_start;
  logic [15:0] expected_transaction;
  logic [6:0]  expected_function;
  logic [10:0] requested_amount;

  modport source (
    output valid, rx_byte, frame_start, expected_transaction, expected_function,
           requested_amount,
    input  ready
  );
  modport sink (
    input  valid, rx_byte, frame_start, expected_transaction, expected_function,
           requested_amount,
    output ready
  );
endinterface

interface mtrp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] data_word;
  logic [4:0]  bit_count;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic        last;

  modport source (
    output valid, item_kind, data_word, bit_count, status, exception_code, last,
    input  ready
  );
  modport sink (
    input  valid, item_kind, data_word, bit_count, status, exception_code, last,
    output ready
  );
endinterface

@@ rtl/mtrp_parser.sv @@
module mtrp_parser #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  mtrp_pkg::in_item_t    item,
  input  logic [7:0]            unit_id,
  output mtrp_pkg::parse_res_t  res
);

  localparam logic [9:0] POS_TID_HI  = 10'd0;
  localparam logic [9:0] POS_TID_LO  = 10'd1;
  localparam logic [9:0] POS_PID_HI  = 10'd2;
  localparam logic [9:0] POS_PID_LO  = 10'd3;
  localparam logic [9:0] POS_LEN_HI  = 10'd4;
  localparam logic [9:0] POS_LEN_LO  = 10'd5;
  localparam logic [9:0] POS_UNIT    = 10'd6;
  localparam logic [9:0] POS_FUNC    = 10'd7;
  localparam logic [9:0] POS_COUNT   = 10'd8;
  localparam logic [9:0] POS_MAX     = 10'd1023;
  localparam logic [16:0] FRAME_LIM  = 17'(MAX_FRAME_BYTES);

  logic [9:0]  pos_r, pos_nxt, pos_e;
  logic [15:0] rem_r, rem_nxt, rem_e, rem_dec;
  logic [7:0]  saved_r, saved_nxt, saved_e;
  logic        exc_r, exc_nxt, exc_e;
  logic        failed_r, failed_nxt, failed_e;
  logic [10:0] ud_r, ud_nxt, ud_e;
  logic [10:0] left;
  logic [3:0]  cnt;
  logic [7:0]  mask;
  logic        is_reg_read, is_bit_read;
  logic        data_emit, stat_emit;
  logic [2:0]  stat_code;
  logic [7:0]  stat_exc;
  mtrp_pkg::out_item_t data_item, stat_item;

  always_comb begin
    // A frame start clears the frame state before the byte is looked at.
    pos_e    = item.frame_start ? '0 : pos_r;
    rem_e    = item.frame_start ? '0 : rem_r;
    saved_e  = item.frame_start ? '0 : saved_r;
    exc_e    = item.frame_start ? 1'b0 : exc_r;
    failed_e = item.frame_start ? 1'b0 : failed_r;
    ud_e     = item.frame_start ? '0 : ud_r;

    pos_nxt    = pos_e;
    rem_nxt    = rem_e;
    saved_nxt  = saved_e;
    exc_nxt    = exc_e;
    failed_nxt = failed_e;
    ud_nxt     = ud_e;

    rem_dec     = rem_e - 16'd1;
    left        = item.requested_amount - ud_e;
    cnt         = (left < 11'd8) ? left[3:0] : 4'd8;
    mask        = 8'((9'd1 << cnt) - 9'd1);
    is_reg_read = (item.expected_function == mtrp_pkg::FC_READ_HOLD) ||
                  (item.expected_function == mtrp_pkg::FC_READ_INREG);
    is_bit_read = (item.expected_function == mtrp_pkg::FC_READ_COILS) ||
                  (item.expected_function == mtrp_pkg::FC_READ_INPUTS);

    data_emit = 1'b0;
    stat_emit = 1'b0;
    stat_code = mtrp_pkg::ST_OK;
    stat_exc  = '0;
    data_item = '0;
    data_item.item_kind = mtrp_pkg::KIND_DATA;

    if (!(failed_e || (pos_e >= POS_FUNC && rem_e == 16'd0))) begin
      pos_nxt = (pos_e < POS_MAX) ? pos_e + 10'd1 : POS_MAX;
      case (pos_e)
        POS_TID_HI: begin
          saved_nxt = item.rx_byte;
        end
        POS_TID_LO: begin
          if ({saved_e, item.rx_byte} != item.expected_transaction) begin
            stat_emit = 1'b1;
            stat_code = mtrp_pkg::ST_BAD_TRANS;
          end
        end
        POS_PID_HI, POS_PID_LO: begin
          if (item.rx_byte != 8'd0) begin
            stat_emit = 1'b1;
            stat_code = mtrp_pkg::ST_BAD_PROTO;
          end
        end
        POS_LEN_HI: begin
          rem_nxt = {item.rx_byte, 8'd0};
        end
        POS_LEN_LO: begin
          rem_nxt = {rem_e[15:8], item.rx_byte};
        end
        POS_UNIT: begin
          if (item.rx_byte != unit_id) begin
            stat_emit = 1'b1;
            stat_code = mtrp_pkg::ST_BAD_UNIT;
          end else if (rem_e < 16'd3 || (17'(rem_e) + 17'd6) > FRAME_LIM) begin
            stat_emit = 1'b1;
            stat_code = mtrp_pkg::ST_BAD_LEN;
          end else begin
            rem_nxt = rem_e - 16'd1;
          end
        end
        default: begin
          rem_nxt = rem_dec;
          if (pos_e == POS_FUNC) begin
            if (item.rx_byte == {1'b1, item.expected_function}) exc_nxt = 1'b1;
          end else if (pos_e == POS_COUNT) begin
            if (exc_e) saved_nxt = item.rx_byte;
          end else if (!exc_e) begin
            if (is_reg_read) begin
              // Data byte index is position minus nine, so an odd position
              // holds the high byte of a register.
              if (pos_e[0]) begin
                saved_nxt = item.rx_byte;
              end else if (ud_e < item.requested_amount) begin
                ud_nxt              = ud_e + 11'd1;
                data_emit           = 1'b1;
                data_item.data_word = {saved_e, item.rx_byte};
                data_item.bit_count = 5'd16;
              end
            end else if (is_bit_read) begin
              if (ud_e < item.requested_amount) begin
                ud_nxt              = ud_e + 11'(cnt);
                data_emit           = 1'b1;
                data_item.data_word = {8'd0, item.rx_byte & mask};
                data_item.bit_count = 5'(cnt);
              end
            end
          end
          if (rem_dec == 16'd0) begin
            stat_emit = 1'b1;
            stat_code = exc_nxt ? mtrp_pkg::ST_EXCEPTION : mtrp_pkg::ST_OK;
            stat_exc  = exc_nxt ? saved_nxt : 8'd0;
          end
        end
      endcase
      if (stat_emit && stat_code != mtrp_pkg::ST_OK &&
          stat_code != mtrp_pkg::ST_EXCEPTION) begin
        failed_nxt = 1'b1;
      end
    end

    stat_item                = '0;
    stat_item.item_kind      = mtrp_pkg::KIND_STATUS;
    stat_item.status         = stat_code;
    stat_item.exception_code = stat_exc;
    stat_item.last           = 1'b1;

    res.push0 = item_valid && (data_emit || stat_emit);
    res.push1 = item_valid && data_emit && stat_emit;
    res.item0 = data_emit ? data_item : stat_item;
    res.item1 = stat_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rem_r    <= '0;
      saved_r  <= '0;
      exc_r    <= 1'b0;
      failed_r <= 1'b0;
      ud_r     <= '0;
    end else if (item_valid) begin
      pos_r    <= pos_nxt;
      rem_r    <= rem_nxt;
      saved_r  <= saved_nxt;
      exc_r    <= exc_nxt;
      failed_r <= failed_nxt;
      ud_r     <= ud_nxt;
    end
  end

  // A second result is only ever the frame status that follows a data item.
  assert property (@(posedge clk) disable iff (!rst_n)
    res.push1 |-> (res.push0 && res.item1.last &&
                   res.item0.item_kind == mtrp_pkg::KIND_DATA))
    else $error("second result is not a status after data");

  // Once a frame has failed, nothing more comes until the next frame start.
  assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && item_valid && !item.frame_start) |-> !res.push0)
    else $error("result emitted on a dead frame");

  // Every data item carries at least one valid bit and at most a full word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res.push0 && res.item0.item_kind == mtrp_pkg::KIND_DATA) |->
      (res.item0.bit_count != 5'd0 && res.item0.bit_count <= 5'd16))
    else $error("data item with a bad bit count");

endmodule

@@ rtl/modbus_tcp_response_parser.sv @@
// Modbus TCP response parser.
// The input channel (in_ch) carries one received byte per beat, together
// with the frame-start flag and the expected transaction id, function code
// and requested amount of the outstanding request. The result channel
// (out_ch) carries data items (register words or groups of up to eight coil
// bits) and exactly one status item with last set at the end of each frame,
// or at the first header error. The unit id register is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle,
// which the block does not enforce; it resets to 1. An accepted byte is
// registered, parsed in the following cycle and its results are written to
// an eight-entry result queue. The first result of a byte is offered once
// it has passed the input register and the parse stage has written it into
// the queue. One byte is taken every cycle as long as the queue, beyond the
// results that the byte in the parse stage may add, still has room for two
// more; a byte gives at most two results. That allows at most four queued
// results with a byte in the parse stage and at most six without one.
// When the receiver stalls, results wait in the queue and in_ch.ready drops
// once the queue holds more than that; nothing is lost. Reset empties the
// queue and the input register, clears the frame state so that the next byte
// is taken as the first byte of a frame, and sets the unit id back to 1.
module modbus_tcp_response_parser #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  mtrp_in_if.sink            in_ch,
  mtrp_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  localparam int                      DEPTH  = mtrp_pkg::QUEUE_DEPTH;
  localparam int                      PTR_W  = mtrp_pkg::QPTR_W;
  localparam int                      CNT_W  = mtrp_pkg::QCNT_W;
  localparam logic [CNT_W-1:0]        ROOM_LIMIT = CNT_W'(DEPTH - 2);

  logic [7:0]           unit_id_r;
  logic                 s1_valid_r;
  mtrp_pkg::in_item_t   s1_item_r;
  mtrp_pkg::parse_res_t res;
  logic                 in_acc, out_acc;

  // Result queue.
  mtrp_pkg::out_item_t  q_mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt, pending;
  mtrp_pkg::out_item_t  head;

  // Room is judged against the byte already in the parse stage, so the queue
  // never has to refuse a result.
  assign pending     = count_r + (s1_valid_r ? CNT_W'(2) : CNT_W'(0));
  assign in_ch.ready = (pending <= ROOM_LIMIT);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r <= 8'd1;
    end else if (cfg_we) begin
      unit_id_r <= cfg_wdata;
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.rx_byte              <= in_ch.rx_byte;
      s1_item_r.frame_start          <= in_ch.frame_start;
      s1_item_r.expected_transaction <= in_ch.expected_transaction;
      s1_item_r.expected_function    <= in_ch.expected_function;
      s1_item_r.requested_amount     <= in_ch.requested_amount;
    end
  end

  mtrp_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .unit_id    (unit_id_r),
    .res        (res)
  );

  // Output side: the head of the queue is offered directly.
  assign head                  = q_mem[rd_ptr_r];
  assign out_ch.valid          = (count_r != '0);
  assign out_ch.item_kind      = head.item_kind;
  assign out_ch.data_word      = head.data_word;
  assign out_ch.bit_count      = head.bit_count;
  assign out_ch.status         = head.status;
  assign out_ch.exception_code = head.exception_code;
  assign out_ch.last           = head.last;
  assign out_acc               = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(res.push0) + PTR_W'(res.push1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(out_acc);
    count_nxt  = count_r + CNT_W'(res.push0) + CNT_W'(res.push1) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push0) begin
      q_mem[wr_ptr_r] <= res.item0;
    end
    if (res.push1) begin
      q_mem[PTR_W'(wr_ptr_r + PTR_W'(1))] <= res.item1;
    end
  end

  // The queue never overflows.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // A byte in the parse stage always finds room for both of its results.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (count_r <= ROOM_LIMIT))
    else $error("parse stage active without queue room");

  // An accepted beat reaches the parse stage on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted beat did not enter the parse stage");

  // Results only appear when a byte was in the parse stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && !s1_valid_r) |=> (count_r == '0))
    else $error("result appeared without a parsed byte");

endmodule
